@@ design/nsp_pkg.sv @@
// Shared types and constants for the phase-accumulator oscillator.
package nsp_pkg;

  // Polynomial sine coefficients in Q.24, rounded to nearest
  localparam logic [31:0] K_A = 32'(((64'd7369528 << 24) + 64'd50000) / 64'd100000);
  localparam logic [31:0] K_B = 32'(((64'd4111008 << 24) + 64'd50000) / 64'd100000);
  localparam logic [31:0] K_C = 32'(((64'd628155 << 24) + 64'd50000) / 64'd100000);

  // Quotient bits of the blep divider (Q0.30)
  localparam int DIV_STEPS = 30;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X2,
    ST_X4,
    ST_AX4,
    ST_BX2,
    ST_P,
    ST_XP,
    ST_SINE,
    ST_DIV,
    ST_W,
    ST_SAW,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_X2,
    OP_X4,
    OP_AX4,
    OP_BX2,
    OP_P,
    OP_XP,
    OP_SINE,
    OP_DIV,
    OP_W,
    OP_SAW,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    logic blep_en;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/nsp_in_if.sv @@
// Input channel: phase increment and blep width words.
interface nsp_in_if #(
  parameter int PHASE_BITS = 24
);
  logic                  valid;
  logic                  ready;
  logic [PHASE_BITS-1:0] phase_inc;
  logic [PHASE_BITS-1:0] blep_width;

  modport source (output valid, output phase_inc, output blep_width, input ready);
  modport sink (input valid, input phase_inc, input blep_width, output ready);
endinterface

@@ design/nsp_out_if.sv @@
// Output channel: sine and sawtooth sample words.
interface nsp_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sine_sample;
  logic signed [SAMPLE_BITS-1:0] saw_sample;

  modport source (output valid, output sine_sample, output saw_sample, input ready);
  modport sink (input valid, input sine_sample, input saw_sample, output ready);
endinterface

@@ design/nsp_ctrl.sv @@
// Sequencer that steps the oscillator datapath through one sample.
module nsp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nsp_pkg::dp_status_t status,
  output nsp_pkg::dp_op_t    op
);
  import nsp_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_X2;
      ST_X2:   state_next = ST_X4;
      ST_X4:   state_next = ST_AX4;
      ST_AX4:  state_next = ST_BX2;
      ST_BX2:  state_next = ST_P;
      ST_P:    state_next = ST_XP;
      ST_XP:   state_next = ST_SINE;
      ST_SINE: state_next = status.blep_en ? ST_DIV : ST_SAW;
      ST_DIV:  if (status.div_last) state_next = ST_W;
      ST_W:    state_next = ST_SAW;
      ST_SAW:  state_next = ST_OUT;
      ST_OUT:  if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) op = OP_LOAD;
      end
      ST_X2:   op = OP_X2;
      ST_X4:   op = OP_X4;
      ST_AX4:  op = OP_AX4;
      ST_BX2:  op = OP_BX2;
      ST_P:    op = OP_P;
      ST_XP:   op = OP_XP;
      ST_SINE: op = OP_SINE;
      ST_DIV:  op = OP_DIV;
      ST_W:    op = OP_W;
      ST_SAW:  op = OP_SAW;
      ST_OUT:  if (status.out_free) op = OP_OUT;
      default: op = OP_NONE;
    endcase
  end

endmodule

@@ design/nsp_datapath.sv @@
// Phase register, shared multiplier, serial divider and output register.
module nsp_datapath #(
  parameter int PHASE_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nsp_pkg::dp_op_t               op,
  input  logic [PHASE_BITS-1:0]         phase_inc,
  input  logic [PHASE_BITS-1:0]         blep_width,
  input  logic                          out_ready,
  output nsp_pkg::dp_status_t           status,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sine_sample,
  output logic signed [SAMPLE_BITS-1:0] saw_sample
);
  import nsp_pkg::*;

  localparam int P        = PHASE_BITS;
  localparam int S        = SAMPLE_BITS;
  localparam int SINE_SH  = 57 - S;
  localparam int SAW_SH   = 33 - S;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam logic [P-1:0] HALF    = {1'b1, {(P-1){1'b0}}};
  localparam logic [P:0]   ONE     = {1'b1, {P{1'b0}}};
  localparam logic [S-1:0] SMP_MAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [36:0] SMAX37 = 37'(SMP_MAX);
  localparam logic signed [36:0] SMIN37 = -SMAX37 - 37'sd1;

  logic [P-1:0]  phase;
  logic [31:0]   x32;
  logic          neg_half;
  logic [P-1:0]  t;
  logic [P-1:0]  dt;
  logic          blep_neg;
  logic          blep_en;
  logic [P-1:0]  rem;
  logic [29:0]   quo;
  logic [CNT_W-1:0] cnt;
  logic [63:0]   prod;
  logic [31:0]   x2;
  logic [31:0]   acc;
  logic [S-1:0]  sine_r;
  logic [S-1:0]  saw_r;

  // Fold and blep setup for the incoming phase
  logic [1:0]    quad;
  logic [P-1:0]  x_fold;
  logic [P-1:0]  t_new;
  logic [P:0]    one_m_dt;
  logic          t_lt;
  logic          t_gt;
  logic [P:0]    one_m_t;

  always_comb begin
    quad = phase[P-1 -: 2];
    case (quad)
      2'd0:    x_fold = phase;
      2'd1:    x_fold = HALF - phase;
      2'd2:    x_fold = phase - HALF;
      default: x_fold = P'(ONE - {1'b0, phase});
    endcase
    t_new    = phase + HALF;
    one_m_dt = ONE - {1'b0, blep_width};
    one_m_t  = ONE - {1'b0, t_new};
    t_lt     = t_new < blep_width;
    t_gt     = {1'b0, t_new} > one_m_dt;
  end

  // Shared multiplier operand select
  logic [31:0] mul_a, mul_b;
  logic [30:0] w;
  assign w = Q30_ONE - {1'b0, quo};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_X2:   begin mul_a = x32;           mul_b = x32;           end
      OP_X4:   begin mul_a = prod[63:32];   mul_b = prod[63:32];   end
      OP_AX4:  begin mul_a = K_A;           mul_b = prod[63:32];   end
      OP_BX2:  begin mul_a = K_B;           mul_b = x2;            end
      OP_XP:   begin mul_a = x32;           mul_b = acc;           end
      OP_W:    begin mul_a = {1'b0, w};     mul_b = {1'b0, w};     end
      default: begin mul_a = '0;            mul_b = '0;            end
    endcase
  end

  // Sine rounding and saturation
  logic [63:0]  y;
  logic [S-1:0] mag;
  always_comb begin
    y   = (prod + (64'd1 << (SINE_SH - 1))) >> SINE_SH;
    mag = (y > 64'(SMP_MAX)) ? SMP_MAX : y[S-1:0];
  end

  // Sawtooth with blep, rounded half up and saturated
  logic [31:0]          t32;
  logic signed [36:0]   saw32, b4, tot, rs;
  always_comb begin
    t32   = 32'(t) << (32 - P);
    saw32 = $signed({4'b0, t32, 1'b0}) - 37'sh1_0000_0000;
    b4    = $signed({4'b0, prod[60:30], 2'b0});
    if (!blep_en)      tot = saw32;
    else if (blep_neg) tot = saw32 + b4;
    else               tot = saw32 - b4;
    rs = (tot + (37'sd1 <<< (SAW_SH - 1))) >>> SAW_SH;
  end

  // Divider step
  logic [P:0] rem2;
  logic       ge;
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, dt};

  // Phase accumulator, advanced on load
  always_ff @(posedge clk) begin
    if (rst) phase <= '0;
    else if (op == OP_LOAD) phase <= phase + phase_inc;
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        x32      <= 32'(x_fold) << (32 - P);
        neg_half <= phase[P-1];
        t        <= t_new;
        dt       <= blep_width;
        blep_neg <= t_lt;
        blep_en  <= t_lt || t_gt;
        rem      <= t_lt ? t_new : P'(one_m_t);
        cnt      <= '0;
      end
      OP_X2:  prod <= mul_a * mul_b;
      OP_X4: begin
        x2   <= prod[63:32];
        prod <= mul_a * mul_b;
      end
      OP_AX4: prod <= mul_a * mul_b;
      OP_BX2: begin
        acc  <= K_C + prod[63:32];
        prod <= mul_a * mul_b;
      end
      OP_P:   acc <= acc - prod[63:32];
      OP_XP:  prod <= mul_a * mul_b;
      OP_SINE: sine_r <= neg_half ? (S'(0) - mag) : mag;
      OP_DIV: begin
        rem <= ge ? P'(rem2 - {1'b0, dt}) : rem2[P-1:0];
        quo <= {quo[28:0], ge};
        cnt <= cnt + 1'b1;
      end
      OP_W:   prod <= mul_a * mul_b;
      OP_SAW: begin
        if (rs > SMAX37)      saw_r <= SMP_MAX;
        else if (rs < SMIN37) saw_r <= SMIN37[S-1:0];
        else                  saw_r <= rs[S-1:0];
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_OUT) begin
      sine_sample <= sine_r;
      saw_sample  <= saw_r;
    end
  end

  assign status.blep_en  = blep_en;
  assign status.div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ design/nco_sine_polyblep_saw_top.sv @@
// Top level of the phase-accumulator oscillator with sine and PolyBLEP saw.
//
// Input channel in_ch carries a phase increment and a blep width per word;
// output channel out_ch returns one sine/saw sample pair per input word.
// A word is taken on a cycle where valid and ready are both high.
// The phase sampled for a word is the one before its increment is added.
// When a blep correction applies, the 30-step restoring divider for the
// blep quotient runs between the sine and saw steps and dominates the
// work for a word. One word is in work at a time: a new word is not
// taken until the sequencer is through with the last one. The sine
// polynomial runs on one shared 32x32 multiplier, one product per cycle.
// The result sits in an output register; a new word is taken while it
// waits, but the finished next result holds until out_ch drains.
// Synchronous reset clears the phase to zero and drops output valid.
module nco_sine_polyblep_saw_top #(
  parameter int PHASE_BITS  = 24,
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  nsp_in_if.sink    in_ch,
  nsp_out_if.source out_ch
);
  import nsp_pkg::*;

  dp_op_t     op;
  dp_status_t status;

  nsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .op       (op)
  );

  nsp_datapath #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .phase_inc   (in_ch.phase_inc),
    .blep_width  (in_ch.blep_width),
    .out_ready   (out_ch.ready),
    .status      (status),
    .out_valid   (out_ch.valid),
    .sine_sample (out_ch.sine_sample),
    .saw_sample  (out_ch.saw_sample)
  );

endmodule

@@ design/nsp_checker.sv @@
// Port-level checks for the oscillator, bound to the top level.
module nsp_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] sine_sample
);
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // Busy after taking a word
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after acceptance");

  // Reset drops output valid
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

  // Sine saturates symmetrically
  a_sine_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sine_sample != SMP_MIN)
    else $error("sine reached negative full scale");

endmodule

bind nco_sine_polyblep_saw_top nsp_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_nsp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .sine_sample (out_ch.sine_sample)
);

@@ verif/tb_top.sv @@
// Testbench for the phase-accumulator oscillator: predicted sine and saw samples.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = 24;
  localparam int SB = 16;
  localparam int N_RANDOM = 2000;
  localparam int CYCLE_LIMIT = 400000;

  // Sample pair held until out_ch delivers it
  typedef struct packed {
    logic signed [SB-1:0] sine;
    logic signed [SB-1:0] saw;
  } sample_pair_t;

  // One row of the directed table; chk marks a typed-in expectation
  typedef struct {
    logic [PB-1:0] inc;
    logic [PB-1:0] dt;
    bit            chk;
    logic [SB-1:0] sine;
    logic [SB-1:0] saw;
  } osc_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_cnt = 0;
  int   err_cnt = 0;
  bit   no_idle = 1'b0;

  sample_pair_t pending_samples[$];
  logic [PB-1:0] osc_phase;

  nsp_in_if #(.PHASE_BITS(PB)) in_ch ();
  nsp_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  nco_sine_polyblep_saw_top #(.PHASE_BITS(PB), .SAMPLE_BITS(SB)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // Polynomial sine magnitude of the folded phase
  function automatic logic [63:0] sine_magnitude(logic [63:0] x);
    logic [63:0] x32, x2, x4, p, y;
    logic [127:0] prod;
    x32 = x << (32 - PB);
    x2 = (x32 * x32) >> 32;
    x4 = (x2 * x2) >> 32;
    p = 64'(nsp_pkg::K_C) + ((64'(nsp_pkg::K_A) * x4) >> 32)
        - ((64'(nsp_pkg::K_B) * x2) >> 32);
    prod = 128'(x32) * 128'(p) + (128'd1 << (56 - SB));
    y = 64'(prod >> (57 - SB));
    if (y > 64'((1 << (SB - 1)) - 1)) y = 64'((1 << (SB - 1)) - 1);
    return y;
  endfunction

  // Signed Q.30 blep correction
  function automatic longint blep_correction(logic [63:0] t, logic [63:0] dt);
    logic [63:0] u, w, one;
    one = 64'd1 << PB;
    if (dt == 0) return 0;
    if (t < dt) begin
      u = (t << 30) / dt;
      w = (64'd1 << 30) - u;
      return -longint'((w * w) >> 30);
    end
    if (t > one - dt) begin
      u = ((one - t) << 30) / dt;
      w = (64'd1 << 30) - u;
      return longint'((w * w) >> 30);
    end
    return 0;
  endfunction

  // Compute the sample pair for the current phase, then advance it
  function automatic sample_pair_t next_samples(logic [PB-1:0] inc, logic [PB-1:0] dt);
    sample_pair_t r;
    logic [63:0] ph, x, mag, t, biased;
    logic [1:0] quad;
    longint saw32, tot, s;
    ph = 64'(osc_phase);
    quad = osc_phase[PB-1:PB-2];
    case (quad)
      2'd0: x = ph;
      2'd1: x = (64'd1 << (PB - 1)) - ph;
      2'd2: x = ph - (64'd1 << (PB - 1));
      default: x = (64'd1 << PB) - ph;
    endcase
    mag = sine_magnitude(x);
    r.sine = (quad < 2) ? SB'(mag) : SB'(-mag);
    t = (ph + (64'd1 << (PB - 1))) & ((64'd1 << PB) - 1);
    saw32 = longint'(t << (32 - PB)) * 2 - (longint'(1) << 32);
    tot = saw32 - blep_correction(t, 64'(dt)) * 4;
    biased = 64'(tot + (longint'(1) << 35)) + (64'd1 << (32 - SB));
    s = longint'(biased >> (33 - SB)) - longint'((64'd1 << 35) >> (33 - SB));
    if (s > longint'((1 << (SB - 1)) - 1)) s = longint'((1 << (SB - 1)) - 1);
    if (s < -longint'(1 << (SB - 1))) s = -longint'(1 << (SB - 1));
    r.saw = SB'(s);
    osc_phase = osc_phase + inc;
    return r;
  endfunction

  // Drive one word and record its prediction; exp_ok overrides with a typed value
  task automatic send_word(logic [PB-1:0] inc, logic [PB-1:0] dt,
                           bit exp_ok, logic [SB-1:0] es, logic [SB-1:0] ew);
    sample_pair_t pred;
    while (!no_idle && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.phase_inc <= inc;
    in_ch.blep_width <= dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = next_samples(inc, dt);
    if (exp_ok && (pred.sine !== es || pred.saw !== ew)) begin
      $error("table row disagrees with predictor: sine %0d/%0d saw %0d/%0d",
             $signed(es), pred.sine, $signed(ew), pred.saw);
      err_cnt++;
    end
    if (exp_ok) begin
      pred.sine = es;
      pred.saw = ew;
    end
    pending_samples.push_back(pred);
    @(negedge clk);
  endtask

  // Random receiver stalls
  always @(negedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 24);
  end

  // Compare each delivered word with the oldest prediction
  always @(posedge clk) begin
    sample_pair_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        $error("output word with nothing expected");
        err_cnt++;
      end else begin
        e = pending_samples.pop_front();
        if (out_ch.sine_sample !== e.sine) begin
          $error("sine_sample expected %0d actual %0d", e.sine, out_ch.sine_sample);
          err_cnt++;
        end
        if (out_ch.saw_sample !== e.saw) begin
          $error("saw_sample expected %0d actual %0d", e.saw, out_ch.saw_sample);
          err_cnt++;
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Stimulus
  initial begin
    osc_row_t tbl[$];
    logic [PB-1:0] inc, dt;
    int k;
    in_ch.valid = 1'b0;
    in_ch.phase_inc = '0;
    in_ch.blep_width = '0;
    out_ch.ready = 1'b0;
    osc_phase = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase zero: sine 0, saw at the half-cycle point is 0 without correction
    tbl.push_back('{24'h400000, 24'h0, 1, 16'sd0, 16'sd0});
    // Quarter cycle: sine saturates to full scale; saw +0.5
    tbl.push_back('{24'h400000, 24'h0, 1, 16'sd32767, 16'sd16384});
    // Half cycle: sine 0, saw at its wrap point is -1
    tbl.push_back('{24'h400000, 24'h0, 1, 16'sd0, -16'sd32768});
    // Three quarters: negative peak stops at -32767, the negation of positive full scale
    tbl.push_back('{24'h400000, 24'h0, 1, -16'sd32767, -16'sd16384});
    // Maximum increment, wraparound, blep widths at the extremes
    tbl.push_back('{24'hFFFFFF, 24'hFFFFFF, 0, 0, 0});
    tbl.push_back('{24'hFFFFFF, 24'h000001, 0, 0, 0});
    tbl.push_back('{24'h000001, 24'h800000, 0, 0, 0});
    tbl.push_back('{24'h7FFFFF, 24'h900000, 0, 0, 0});
    tbl.push_back('{24'h800001, 24'h010000, 0, 0, 0});
    tbl.push_back('{24'h000000, 24'h100000, 0, 0, 0});
    tbl.push_back('{24'h7FF000, 24'h020000, 0, 0, 0});
    tbl.push_back('{24'h001000, 24'h020000, 0, 0, 0});
    tbl.push_back('{24'h555555, 24'hAAAAAA, 0, 0, 0});
    tbl.push_back('{24'hAAAAAA, 24'h555555, 0, 0, 0});
    foreach (tbl[i]) send_word(tbl[i].inc, tbl[i].dt, tbl[i].chk, tbl[i].sine, tbl[i].saw);

    // Hold off until every expected word has come back
    in_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);

    for (k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= 800 && k < 1000);
      case ($urandom_range(3))
        0: inc = PB'($urandom_range(24'h3FFFF));
        1: inc = PB'($urandom);
        2: inc = PB'(24'h800000 ^ $urandom_range(255));
        default: inc = PB'({$urandom_range(1), 23'h0} | $urandom_range(24'hFFF));
      endcase
      case ($urandom_range(4))
        0: dt = '0;
        1: dt = PB'($urandom_range(24'h0FFFFF));
        2: dt = PB'($urandom);
        3: dt = PB'(inc + $urandom_range(24'hFFFF));
        default: dt = PB'({1'b1, 23'(dt)} | $urandom_range(24'hFF));
      endcase
      send_word(inc, dt, 0, 0, 0);
    end
    no_idle = 1'b0;
    in_ch.valid <= 1'b0;

    while (pending_samples.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule
